### hdl/imsnr_pkg.sv
// ============================================================================
// imsnr_pkg: shared types and constants of the image MSE / SNR meter
// Holds the build sizes, the derived datapath widths, the fixed-point log
// constants and the packed structs that travel between the blocks.
// ============================================================================
package imsnr_pkg;

    // Build sizes.
    localparam int COUNT_BITS  = 24;
    localparam int FRAC_BITS   = 8;

    // Derived widths.
    localparam int EN_W        = COUNT_BITS + 16;
    localparam int TOT_W       = COUNT_BITS + 1;
    localparam int MSE_W       = 24;
    localparam int SNR_W       = 16;
    localparam int DIVD_W      = EN_W + FRAC_BITS + 1;
    localparam int DIV_CNT_W   = $clog2(DIVD_W);
    localparam int LOG_FRAC    = 16;
    localparam int P_W         = $clog2(EN_W);
    localparam int LOG_W       = P_W + LOG_FRAC;
    localparam int M_W         = 31;
    localparam int K_W         = 18;
    localparam int PROD_W      = LOG_W + K_W;
    localparam int RND_SHIFT   = 24;
    localparam int RND_W       = PROD_W + 1 - RND_SHIFT;

    // 10*log10(2) in Q16.
    localparam logic [K_W-1:0] TEN_LOG10_2_Q16 = K_W'(197283);

    localparam logic [MSE_W-1:0] MSE_MAX = {MSE_W{1'b1}};
    localparam logic signed [SNR_W-1:0] SNR_MAX  = 16'sh7FFF;
    localparam logic signed [SNR_W-1:0] SNR_MIN  = 16'sh8000;
    localparam logic signed [SNR_W-1:0] SNR_ZERO = 16'sh0000;

    // Job queue between accumulator and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] sample_ref;
        logic [7:0] sample_test;
        logic       last_sample;
    } imsnr_in_t;

    typedef struct packed {
        logic [MSE_W-1:0]        mse_q8;
        logic signed [SNR_W-1:0] snr_db_q8;
        logic                    error_zero;
        logic                    signal_zero;
        logic                    count_overflow;
    } imsnr_out_t;

    // Sums of one finished image, handed from the front to the back end.
    typedef struct packed {
        logic [EN_W-1:0]  signal_energy;
        logic [EN_W-1:0]  error_energy;
        logic [TOT_W-1:0] sample_total;
        logic             overflow_seen;
    } imsnr_job_t;

    // Queue write request from the front end.
    typedef struct packed {
        logic push;
    } imsnr_qctl_t;

endpackage

### hdl/imsnr_front.sv
// ============================================================================
// imsnr_front: sample accumulator
// Adds squared reference values and squared differences, counts samples and
// hands the finished sums of an image to the job queue.
// ============================================================================
module imsnr_front
    import imsnr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  imsnr_in_t   sample,
    output imsnr_qctl_t qctl,
    input  logic        queue_full,
    output imsnr_job_t  job
);

    logic [EN_W-1:0]  sig_reg, sig_next;
    logic [EN_W-1:0]  err_reg, err_next;
    logic [TOT_W-1:0] tot_reg, tot_next;
    logic             ovf_reg, ovf_next;

    logic             take;
    logic [7:0]       diff;
    logic [15:0]      ref_sq;
    logic [15:0]      diff_sq;

    assign sample_ready = !queue_full;
    assign take         = sample_valid && sample_ready;

    assign diff    = (sample.sample_ref >= sample.sample_test)
                   ? (sample.sample_ref - sample.sample_test)
                   : (sample.sample_test - sample.sample_ref);
    assign ref_sq  = 16'(sample.sample_ref * sample.sample_ref);
    assign diff_sq = 16'(diff * diff);

    // Updated sums including the current sample; a full count drops it.
    always_comb
    begin
        sig_next = sig_reg;
        err_next = err_reg;
        tot_next = tot_reg;
        ovf_next = ovf_reg;
        if (tot_reg[COUNT_BITS])
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            sig_next = sig_reg + EN_W'(ref_sq);
            err_next = err_reg + EN_W'(diff_sq);
            tot_next = tot_reg + TOT_W'(1);
        end
    end

    assign job.signal_energy = sig_next;
    assign job.error_energy  = err_next;
    assign job.sample_total  = tot_next;
    assign job.overflow_seen = ovf_next;

    assign qctl.push = take && sample.last_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_reg <= '0;
            err_reg <= '0;
            tot_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (take)
        begin
            if (sample.last_sample)
            begin
                sig_reg <= '0;
                err_reg <= '0;
                tot_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                sig_reg <= sig_next;
                err_reg <= err_next;
                tot_reg <= tot_next;
                ovf_reg <= ovf_next;
            end
        end
    end

endmodule

### hdl/imsnr_queue.sv
// ============================================================================
// imsnr_queue: short job queue
// Holds finished image sums until the back end is free to process them.
// ============================================================================
module imsnr_queue
    import imsnr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  imsnr_qctl_t qctl,
    input  imsnr_job_t  wr_job,
    output logic        full,
    output logic        head_valid,
    input  logic        pop,
    output imsnr_job_t  head_job
);

    imsnr_job_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (qctl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (qctl.push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !qctl.push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (qctl.push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hdl/imsnr_back.sv
// ============================================================================
// imsnr_back: result sequencer
// Computes the rounded mean by a bit-serial divider, both log2 values by a
// normalize-and-square unit shared between the two sums, and the dB value.
// ============================================================================
module imsnr_back
    import imsnr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    output logic       job_pop,
    input  imsnr_job_t job,
    output logic       result_valid,
    input  logic       result_ready,
    output imsnr_out_t result
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_NORM = 6'b000100,
        ST_SQR  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_FIN  = 6'b100000
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic                 res_valid_reg, res_valid_next;
    imsnr_out_t           res_reg, res_next;

    logic [EN_W-1:0]      sig_reg, sig_next;
    logic [EN_W-1:0]      err_reg, err_next;
    logic [TOT_W-1:0]     n_reg, n_next;
    logic                 ovf_reg, ovf_next;
    logic [DIVD_W-1:0]    dvd_reg, dvd_next;
    logic [TOT_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MSE_W-1:0]     mse_reg, mse_next;
    logic [EN_W-1:0]      x_reg, x_next;
    logic [P_W-1:0]       p_reg, p_next;
    logic [M_W-1:0]       m_reg, m_next;
    logic [LOG_FRAC-1:0]  frac_reg, frac_next;
    logic                 sel_reg, sel_next;
    logic [LOG_W-1:0]     log_sig_reg, log_sig_next;
    logic                 neg_reg, neg_next;
    logic [LOG_W-1:0]     mag_reg, mag_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;

    // Divider step.
    logic [TOT_W:0]       rem_sh;
    logic                 rem_ge;
    logic [DIVD_W-1:0]    dvd_init;
    logic [DIVD_W-1:0]    quot;
    // Log step.
    logic [EN_W+M_W-1:0]  x_wide;
    logic [2*M_W-1:0]     sq;
    logic [M_W:0]         sq_hi;
    logic [LOG_FRAC-1:0]  frac_step;
    logic [LOG_W-1:0]     log_val;
    logic [LOG_W:0]       log_diff;
    // Final rounding.
    logic [PROD_W:0]      prod_rnd;
    logic [RND_W-1:0]     rnd;
    logic                 ez;
    logic                 sz;
    logic signed [SNR_W-1:0] snr;

    assign rem_sh   = {rem_reg, dvd_reg[DIVD_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, n_reg});
    assign dvd_init = {1'b0, job.error_energy, {FRAC_BITS{1'b0}}}
                    + DIVD_W'(job.sample_total >> 1);
    assign quot     = {dvd_reg[DIVD_W-2:0], rem_ge};

    assign x_wide    = {x_reg, {M_W{1'b0}}};
    assign sq        = m_reg * m_reg;
    assign sq_hi     = sq[2*M_W-1:M_W-1];
    assign frac_step = {frac_reg[LOG_FRAC-2:0], sq_hi[M_W]};
    assign log_val   = {p_reg, frac_step};
    assign log_diff  = {1'b0, log_sig_reg} - {1'b0, log_val};

    assign prod_rnd = {1'b0, prod_reg} + (PROD_W+1)'(1 << (RND_SHIFT - 1));
    assign rnd      = prod_rnd[PROD_W:RND_SHIFT];
    assign ez       = (err_reg == '0);
    assign sz       = (sig_reg == '0);

    always_comb
    begin
        if (ez && sz)
        begin
            snr = SNR_ZERO;
        end
        else if (ez)
        begin
            snr = SNR_MAX;
        end
        else if (sz)
        begin
            snr = SNR_MIN;
        end
        else if (neg_reg)
        begin
            snr = (rnd > RND_W'(32768)) ? SNR_MIN : SNR_W'(-rnd);
        end
        else
        begin
            snr = (rnd > RND_W'(32767)) ? SNR_MAX : SNR_W'(rnd);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        res_valid_next = res_valid_reg && !result_ready;
        sig_next     = sig_reg;
        err_next     = err_reg;
        n_next       = n_reg;
        ovf_next     = ovf_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        mse_next     = mse_reg;
        x_next       = x_reg;
        p_next       = p_reg;
        m_next       = m_reg;
        frac_next    = frac_reg;
        sel_next     = sel_reg;
        log_sig_next = log_sig_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        prod_next    = prod_reg;
        job_pop      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    sig_next   = job.signal_energy;
                    err_next   = job.error_energy;
                    n_next     = job.sample_total;
                    ovf_next   = job.overflow_seen;
                    dvd_next   = dvd_init;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? TOT_W'(rem_sh - {1'b0, n_reg}) : rem_sh[TOT_W-1:0];
                dvd_next = quot;
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIVD_W - 1))
                begin
                    mse_next = (|quot[DIVD_W-1:MSE_W]) ? MSE_MAX : quot[MSE_W-1:0];
                    x_next   = sig_reg;
                    p_next   = P_W'(EN_W - 1);
                    sel_next = 1'b0;
                    state_next = (ez || sz) ? ST_FIN : ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (x_reg[EN_W-1])
                begin
                    m_next     = x_wide[EN_W+M_W-1 -: M_W];
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_SQR;
                end
                else
                begin
                    x_next = {x_reg[EN_W-2:0], 1'b0};
                    p_next = p_reg - P_W'(1);
                end
            end
            ST_SQR:
            begin
                m_next    = sq_hi[M_W] ? sq_hi[M_W:1] : sq_hi[M_W-1:0];
                frac_next = frac_step;
                cnt_next  = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(LOG_FRAC - 1))
                begin
                    if (!sel_reg)
                    begin
                        log_sig_next = log_val;
                        sel_next     = 1'b1;
                        x_next       = err_reg;
                        p_next       = P_W'(EN_W - 1);
                        state_next   = ST_NORM;
                    end
                    else
                    begin
                        neg_next   = log_diff[LOG_W];
                        mag_next   = log_diff[LOG_W] ? LOG_W'(-log_diff)
                                                     : log_diff[LOG_W-1:0];
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(mag_reg * TEN_LOG10_2_Q16);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_next.mse_q8         = mse_reg;
                    res_next.snr_db_q8      = snr;
                    res_next.error_zero     = ez;
                    res_next.signal_zero    = sz;
                    res_next.count_overflow = ovf_reg;
                    res_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        sig_reg     <= sig_next;
        err_reg     <= err_next;
        n_reg       <= n_next;
        ovf_reg     <= ovf_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        mse_reg     <= mse_next;
        x_reg       <= x_next;
        p_reg       <= p_next;
        m_reg       <= m_next;
        frac_reg    <= frac_next;
        sel_reg     <= sel_next;
        log_sig_reg <= log_sig_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        prod_reg    <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

### hdl/image_mse_snr_meter.sv
// ============================================================================
// image_mse_snr_meter: streaming image MSE and SNR meter
// Throughput: one sample transfer per cycle while the job queue holds fewer than two images.
// Reset: rst_n clears the sums, the sample count, the job queue and the result valid flag.
// ============================================================================
//
// The design has a front end and a back end joined by a two-entry job queue.
//
// The front end accumulates one sample per cycle: the squared reference value
// goes into the signal energy sum, the squared difference into the error
// energy sum, and the sample count advances. Once the count reaches the limit
// further samples are dropped and an overflow flag is kept. On a sample that
// carries the last-sample mark, the sums including that sample are pushed into
// the job queue and the accumulators return to zero, ready for the next
// image. Sample transfers stall only while the queue is full.
//
// The back end takes one job at a time. A restoring divider produces the
// rounded mean squared error one quotient bit per cycle. Then a shared log2
// unit normalizes each sum one bit per cycle and squares the mantissa sixteen
// times to build the fraction bits; the difference of the two logs is scaled
// by 10*log10(2) and rounded to Q8.8 dB. A zero error or signal skips the log;
// one alone saturates the dB value, both give zero. The finished result sits
// in an output register, so the back end can take the next job while it waits.
//
module image_mse_snr_meter
    import imsnr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_ready,
    input  imsnr_in_t  sample,
    output logic       result_valid,
    input  logic       result_ready,
    output imsnr_out_t result
);

    imsnr_qctl_t qctl;
    imsnr_job_t  push_job;
    imsnr_job_t  head_job;
    logic        queue_full;
    logic        head_valid;
    logic        head_pop;

    // Accumulator: one sample transfer per cycle while the job queue is not full.
    imsnr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .qctl         (qctl),
        .queue_full   (queue_full),
        .job          (push_job)
    );

    // Finished image sums waiting for the back end.
    imsnr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .qctl       (qctl),
        .wr_job     (push_job),
        .full       (queue_full),
        .head_valid (head_valid),
        .pop        (head_pop),
        .head_job   (head_job)
    );

    // Divider, log unit and result register.
    imsnr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (head_valid),
        .job_pop      (head_pop),
        .job          (head_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
